// ===== src/sacache_pkg.sv =====
// Shared types and codes for the set-associative cache tag and LRU block.
package sacache_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

endpackage

// ===== src/set_assoc_cache_tag_lru.sv =====
// Set-associative cache tag array with true-LRU replacement and dirty-line tracking.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  access    | start in, busy out         | kind, address
//  result    | done strobe out            | hit, way_used, dirty_evict, forward_to_next
//  config    | cfg_valid in, cfg_ready out| cfg_data (next level enable)
//
//  An access reads the set's row from the tag and state memories, then updates
//  the row, writes it back and registers the result. busy stays high from
//  acceptance until done, so the next access reads the written-back row.
//  After reset a clearing pass writes all 2**floor(log2(SET_COUNT)) state rows
//  (busy high); config writes are taken throughout.
//  done is high for exactly one cycle; the receiver cannot stall it.
module set_assoc_cache_tag_lru #(
    parameter int BLOCK_BYTES  = 32,
    parameter int SET_COUNT    = 128,
    parameter int WAYS         = 4,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    kind,
    input  logic [ADDRESS_BITS-1:0] address,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data,
    output logic                    done,
    output logic                    hit,
    output logic [1:0]              way_used,
    output logic                    dirty_evict,
    output logic                    forward_to_next
);
    import sacache_pkg::*;

    localparam int OB      = $clog2(BLOCK_BYTES + 1) - 1;
    localparam int IB      = $clog2(SET_COUNT + 1) - 1;
    localparam int ROWS    = 1 << IB;
    localparam int ROW_AW  = (IB > 0) ? IB : 1;
    localparam int SH      = OB + IB;
    localparam int TAG_RAW = ADDRESS_BITS - SH;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int IDX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int META_W  = 2 * WAYS + WAYS * IDX_W;

    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef logic [WAYS-1:0][IDX_W-1:0] age_row_t;

    state_t state_reg, state_next;
    logic [ROW_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic nle_reg;

    logic              kind_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [ROW_AW-1:0] set_reg;

    tag_row_t         tag_mem [ROWS];
    logic [META_W-1:0] meta_mem [ROWS];
    tag_row_t          tag_rdata_reg;
    logic [META_W-1:0] meta_rdata_reg;

    logic              done_reg;
    logic              hit_reg;
    logic [1:0]        way_reg;
    logic              wb_reg;
    logic              fwd_reg;

    logic                    accept;
    logic [ADDRESS_BITS-1:0] addr_set;
    logic [ADDRESS_BITS-1:0] addr_tag;
    logic [ROW_AW-1:0]       set_c;
    logic [TAG_W-1:0]        tag_c;

    logic [WAYS-1:0] valid_r, dirty_r, valid_n, dirty_n;
    age_row_t        age_r, age_n, clr_age;
    tag_row_t        tag_n;
    logic            hit_c, inv_found, wb_c, fwd_c;
    logic [IDX_W-1:0] hway, iway, lway, way_c, old_age;

    logic              meta_we;
    logic [ROW_AW-1:0] meta_waddr;
    logic [META_W-1:0] meta_wdata;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign addr_set = address >> OB;
    assign addr_tag = address >> SH;
    assign set_c    = (IB == 0) ? '0 : addr_set[ROW_AW-1:0];
    assign tag_c    = addr_tag[TAG_W-1:0];

    assign valid_r = meta_rdata_reg[META_W-1 -: WAYS];
    assign dirty_r = meta_rdata_reg[META_W-WAYS-1 -: WAYS];
    assign age_r   = meta_rdata_reg[WAYS*IDX_W-1:0];

    always_comb
    begin
        hit_c     = 1'b0;
        hway      = '0;
        inv_found = 1'b0;
        iway      = '0;
        lway      = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_c && valid_r[w] && tag_rdata_reg[w] == tag_reg)
            begin
                hit_c = 1'b1;
                hway  = IDX_W'(w);
            end
            if (!valid_r[w])
            begin
                inv_found = 1'b1;
                iway      = IDX_W'(w);
            end
            if (age_r[w] == '0)
            begin
                lway = IDX_W'(w);
            end
        end
        if (hit_c)
        begin
            way_c = hway;
        end
        else if (inv_found)
        begin
            way_c = iway;
        end
        else
        begin
            way_c = lway;
        end
        wb_c    = !hit_c && !inv_found && dirty_r[lway];
        fwd_c   = !hit_c && (kind_reg == KIND_WRITE) && nle_reg;
        old_age = age_r[way_c];

        valid_n = valid_r;
        dirty_n = dirty_r;
        tag_n   = tag_rdata_reg;
        age_n   = age_r;
        for (int w = 0; w < WAYS; w++)
        begin
            if (IDX_W'(w) == way_c)
            begin
                age_n[w] = IDX_W'(WAYS - 1);
            end
            else if (age_r[w] > old_age)
            begin
                age_n[w] = age_r[w] - 1'b1;
            end
        end
        valid_n[way_c] = 1'b1;
        if (hit_c)
        begin
            if (kind_reg == KIND_WRITE)
            begin
                dirty_n[way_c] = 1'b1;
            end
        end
        else
        begin
            dirty_n[way_c] = 1'b0;
            tag_n[way_c]   = tag_reg;
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            clr_age[w] = IDX_W'(w);
        end
    end

    always_comb
    begin
        meta_we    = 1'b0;
        meta_waddr = set_reg;
        meta_wdata = {valid_n, dirty_n, age_n};
        case (state_reg)
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_cnt_reg;
                meta_wdata = {{WAYS{1'b0}}, {WAYS{1'b0}}, clr_age};
            end
            ST_LOOKUP:
            begin
                meta_we = 1'b1;
            end
            default:
            begin
                meta_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            nle_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= (state_reg == ST_LOOKUP);
            if (cfg_valid && cfg_ready)
            begin
                nle_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            tag_reg  <= tag_c;
            set_reg  <= set_c;
        end
        if (state_reg == ST_LOOKUP)
        begin
            hit_reg <= hit_c;
            way_reg <= 2'(way_c);
            wb_reg  <= wb_c;
            fwd_reg <= fwd_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOKUP)
        begin
            tag_mem[set_reg] <= tag_n;
        end
        if (accept)
        begin
            tag_rdata_reg <= tag_mem[set_c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (accept)
        begin
            meta_rdata_reg <= meta_mem[set_c];
        end
    end

    assign done            = done_reg;
    assign hit             = hit_reg;
    assign way_used        = way_reg;
    assign dirty_evict     = wb_reg;
    assign forward_to_next = fwd_reg;

    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_LOOKUP))
        else $error("result without a lookup cycle");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted access did not enter lookup");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!dirty_evict && !forward_to_next))
        else $error("hit reported write-back or forward");

    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        (done && forward_to_next) |-> (nle_reg && kind_reg == KIND_WRITE))
        else $error("forward without enabled write miss");

endmodule

// ===== tb/sv/set_assoc_cache_tag_lru_tb.sv =====
// Self-checking testbench for the set-associative cache tag and LRU block.
`timescale 1ns / 100ps

module set_assoc_cache_tag_lru_tb;
    import sacache_pkg::*;

    localparam int BLOCK_BYTES  = 32;
    localparam int SET_COUNT    = 128;
    localparam int WAYS         = 4;
    localparam int ADDRESS_BITS = 32;
    localparam int TAG_WIDTH    = 20;
    localparam int SET_BITS     = 7;
    localparam int POOL_TAGS    = 6;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 75;
    localparam int ROWS         = 18;
    localparam int CYCLE_LIMIT  = 60000;

    typedef struct packed {
        logic       hit;
        logic [1:0] way;
        logic       wb;
        logic       fwd;
    } lookup_t;

    typedef enum logic [1:0] {
        CFG_KEEP,
        CFG_OFF,
        CFG_ON
    } cfg_action_t;

    typedef struct {
        cfg_action_t       cfg;
        logic              rw;
        logic [31:0]       addr;
        bit                typed;
        lookup_t           want;
    } access_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    kind;
    logic [ADDRESS_BITS-1:0] address;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic                    cfg_data;
    logic                    done;
    logic                    hit;
    logic [1:0]              way_used;
    logic                    dirty_evict;
    logic                    forward_to_next;

    bit                      row_typed;
    lookup_t                 row_want;

    logic [TAG_WIDTH-1:0]    line_tag   [SET_COUNT][WAYS];
    bit                      line_valid [SET_COUNT][WAYS];
    bit                      line_dirty [SET_COUNT][WAYS];
    logic [1:0]              line_age   [SET_COUNT][WAYS];
    bit                      fwd_enable;

    lookup_t                 expected_lookups [$];
    logic [TAG_WIDTH-1:0]    tag_pool [POOL_TAGS];

    int                      mismatches;
    int                      accesses_seen;
    int                      hits_seen;
    int                      evictions_seen;
    int                      forwards_seen;
    int                      cfg_writes;
    int                      cycle_count;

    access_row_t directed_rows [ROWS] = '{
        '{CFG_OFF,  KIND_READ,  32'h0000_0000, 1'b1, '{1'b0, 2'd3, 1'b0, 1'b0}},
        '{CFG_KEEP, KIND_READ,  32'h0000_0000, 1'b1, '{1'b1, 2'd3, 1'b0, 1'b0}},
        '{CFG_KEEP, KIND_WRITE, 32'h0000_001F, 1'b1, '{1'b1, 2'd3, 1'b0, 1'b0}},
        '{CFG_KEEP, KIND_WRITE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd3, 1'b0, 1'b0}},
        '{CFG_KEEP, KIND_READ,  32'hFFFF_FFE0, 1'b1, '{1'b1, 2'd3, 1'b0, 1'b0}},
        '{CFG_KEEP, KIND_READ,  32'h0000_1000, 1'b1, '{1'b0, 2'd2, 1'b0, 1'b0}},
        '{CFG_KEEP, KIND_WRITE, 32'h0000_2000, 1'b1, '{1'b0, 2'd1, 1'b0, 1'b0}},
        '{CFG_KEEP, KIND_READ,  32'h0000_3000, 1'b1, '{1'b0, 2'd0, 1'b0, 1'b0}},
        '{CFG_KEEP, KIND_READ,  32'h0000_4000, 1'b1, '{1'b0, 2'd3, 1'b1, 1'b0}},
        '{CFG_ON,   KIND_WRITE, 32'h0000_5000, 1'b0, '0},
        '{CFG_KEEP, KIND_WRITE, 32'h0000_6000, 1'b0, '0},
        '{CFG_KEEP, KIND_WRITE, 32'h0000_4000, 1'b0, '0},
        '{CFG_KEEP, KIND_WRITE, 32'h8000_0000, 1'b0, '0},
        '{CFG_KEEP, KIND_READ,  32'h7FFF_FFFF, 1'b0, '0},
        '{CFG_KEEP, KIND_WRITE, 32'hFFFF_FFFF, 1'b0, '0},
        '{CFG_KEEP, KIND_READ,  32'h0000_0FE0, 1'b0, '0},
        '{CFG_OFF,  KIND_WRITE, 32'h1234_5678, 1'b0, '0},
        '{CFG_KEEP, KIND_WRITE, 32'hFFFF_F000, 1'b0, '0}
    };

    set_assoc_cache_tag_lru #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .SET_COUNT    (SET_COUNT),
        .WAYS         (WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .address         (address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .done            (done),
        .hit             (hit),
        .way_used        (way_used),
        .dirty_evict     (dirty_evict),
        .forward_to_next (forward_to_next)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic lookup_t predict_lookup(input logic rw, input logic [31:0] addr);
        lookup_t                 r;
        logic [SET_BITS-1:0]     set;
        logic [TAG_WIDTH-1:0]    tag;
        logic [1:0]              old;
        int                      victim;
        bit                      found;
        r      = '0;
        set    = addr[11:5];
        tag    = addr[31:12];
        victim = 0;
        found  = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && line_valid[set][w] && line_tag[set][w] == tag)
            begin
                found  = 1'b1;
                victim = w;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            if (rw == KIND_WRITE)
                line_dirty[set][victim] = 1'b1;
        end
        else
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (!line_valid[set][w])
                begin
                    victim = w;
                    found  = 1'b1;
                end
            end
            if (!found)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (line_age[set][w] == 2'd0)
                    begin
                        victim = w;
                        r.wb   = line_dirty[set][w];
                    end
                end
            end
            line_valid[set][victim] = 1'b1;
            line_tag[set][victim]   = tag;
            line_dirty[set][victim] = 1'b0;
            r.fwd = (rw == KIND_WRITE) && fwd_enable;
        end
        old = line_age[set][victim];
        if (old != 2'(WAYS - 1))
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (w != victim && line_age[set][w] > old)
                    line_age[set][w] = line_age[set][w] - 2'd1;
            end
            line_age[set][victim] = 2'(WAYS - 1);
        end
        r.way = victim[1:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_address();
        logic [SET_BITS-1:0] set;
        logic [31:0]         a;
        case ($urandom_range(0, 4))
            0: set = '0;
            1: set = 7'd1;
            2: set = 7'd2;
            3: set = '1;
            default: set = 7'($urandom_range(0, SET_COUNT - 1));
        endcase
        if ($urandom_range(0, 9) < 7)
            a = {tag_pool[$urandom_range(0, POOL_TAGS - 1)], set, 5'($urandom_range(0, 31))};
        else
            a = $urandom;
        return a;
    endfunction

    task automatic issue(input logic rw, input logic [31:0] addr, input int gap,
                         input bit typed, input lookup_t want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        kind      <= rw;
        address   <= addr;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge clk); while (busy);
    endtask

    task automatic settle_then_set_forwarding(input logic value);
        start <= 1'b0;
        @(posedge clk);
        while (expected_lookups.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic int idle_burst();
        return ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 12)) : 0;
    endfunction

    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                fwd_enable = cfg_data;
                cfg_writes++;
            end
            if (done)
            begin
                got = '{hit, way_used, dirty_evict, forward_to_next};
                accesses_seen++;
                hits_seen      += got.hit;
                evictions_seen += got.wb;
                forwards_seen  += got.fwd;
                if (expected_lookups.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result hit=%0b way=%0d wb=%0b fwd=%0b",
                                 got.hit, got.way, got.wb, got.fwd);
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected hit=%0b way=%0d wb=%0b fwd=%0b,",
                                      " got hit=%0b way=%0d wb=%0b fwd=%0b"},
                                     want.hit, want.way, want.wb, want.fwd,
                                     got.hit, got.way, got.wb, got.fwd);
                    end
                end
            end
            if (start && !busy)
            begin
                want = predict_lookup(kind, address);
                if (row_typed)
                    want = row_want;
                expected_lookups.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL set_assoc_cache_tag_lru");
            $finish;
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = KIND_READ;
        address    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        row_typed  = 1'b0;
        row_want   = '0;
        fwd_enable = 1'b0;
        for (int s = 0; s < SET_COUNT; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                line_tag[s][w]   = '0;
                line_valid[s][w] = 1'b0;
                line_dirty[s][w] = 1'b0;
                line_age[s][w]   = 2'(w);
            end
        end
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int t = 2; t < POOL_TAGS; t++)
            tag_pool[t] = TAG_WIDTH'($urandom);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < ROWS; i++)
        begin
            if (directed_rows[i].cfg != CFG_KEEP)
                settle_then_set_forwarding(directed_rows[i].cfg == CFG_ON);
            issue(directed_rows[i].rw, directed_rows[i].addr, idle_burst(),
                  directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 2)
                settle_then_set_forwarding(p == 0);
            else
                settle_then_set_forwarding(1'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue(1'($urandom_range(0, 1)), pick_address(),
                      (p == PHASES - 1) ? 0 : idle_burst(), 1'b0, '0);
        end

        start <= 1'b0;
        @(posedge clk);
        while (expected_lookups.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        mismatches += expected_lookups.size();

        $display("covered %0d accesses: %0d hits, %0d dirty evictions, %0d forwarded write misses",
                 accesses_seen, hits_seen, evictions_seen, forwards_seen);
        $display("forwarding enable written %0d times, %0d mismatches", cfg_writes, mismatches);
        if (mismatches == 0)
            $display("PASS set_assoc_cache_tag_lru");
        else
            $display("FAIL set_assoc_cache_tag_lru");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sacache_pkg.sv
src/set_assoc_cache_tag_lru.sv
tb/sv/set_assoc_cache_tag_lru_tb.sv
